// ----- src/s4p_pkg.sv -----
// package with item types, codes and helpers for the socks4 request parser
`timescale 1ns / 1ps
package s4p_pkg;

	localparam logic [15:0] LIMIT_RESET = 16'd512;
	localparam logic [15:0] HEADER_LAST = 16'd7;

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_USERID = 3'd1;
	localparam logic [2:0] PH_HOST = 3'd2;
	localparam logic [2:0] PH_FORWARD = 3'd3;
	localparam logic [2:0] PH_ERROR = 3'd4;

	localparam logic [2:0] K_FORWARD = 3'd0;
	localparam logic [2:0] K_REPLY = 3'd1;
	localparam logic [2:0] K_HOSTBYTE = 3'd2;
	localparam logic [2:0] K_CONNECT = 3'd3;
	localparam logic [2:0] K_ERROR = 3'd4;

	localparam logic [1:0] E_NONE = 2'd0;
	localparam logic [1:0] E_COMMAND = 2'd1;
	localparam logic [1:0] E_PORT = 2'd2;
	localparam logic [1:0] E_LENGTH = 2'd3;

	localparam logic [7:0] REPLY_GRANTED = 8'h5A;
	localparam logic [7:0] REPLY_REJECTED = 8'h5B;
	localparam logic [7:0] CMD_CONNECT = 8'h01;
	localparam logic [2:0] REPLY_LAST = 3'd7;
	localparam logic [2:0] REPLY_CODE_POS = 3'd1;

	typedef struct packed {
		logic       operation;
		logic [7:0] data_byte;
		logic       connect_ok;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  byte_value;
		logic [15:0] dest_port;
		logic [31:0] dest_ipv4;
		logic        uses_hostname;
		logic [1:0]  error_code;
		logic        last;
	} out_item_t;

	// what one input item leaves for the output side
	typedef struct packed {
		logic       emit;
		logic       reply;
		logic [7:0] reply_code;
		logic       tail_error;
		out_item_t  item;
	} burst_t;

	function automatic out_item_t reply_item(input logic [2:0] idx, input logic [7:0] code,
		input logic tail);
		out_item_t r;
		r = '0;
		r.kind = K_REPLY;
		r.byte_value = (idx == REPLY_CODE_POS) ? code : 8'h00;
		r.last = (idx == REPLY_LAST) && !tail;
		return r;
	endfunction

	function automatic out_item_t error_item(input logic [1:0] code);
		out_item_t r;
		r = '0;
		r.kind = K_ERROR;
		r.error_code = code;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

// ----- src/s4p_parse.sv -----
// request parser: handshake state and the result decision for one item
`timescale 1ns / 1ps
module s4p_parse import s4p_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  in_item_t    item,
	input  logic [15:0] limit,
	output burst_t      burst
);

	logic [2:0]  phase_q, phase_d;
	logic [15:0] count_q, count_d;
	logic [7:0]  command_q, command_d;
	logic [15:0] port_q, port_d;
	logic [31:0] addr_q, addr_d;
	logic        over;
	logic        bump;
	out_item_t   single;

	assign over = count_q >= limit;

	always_comb begin
		phase_d = phase_q;
		command_d = command_q;
		port_d = port_q;
		addr_d = addr_q;
		bump = 1'b0;
		burst = '0;
		single = '0;
		single.last = 1'b1;
		if (phase_q >= PH_ERROR) begin
			burst = '0;
		end else if (item.operation) begin
			burst.emit = 1'b1;
			burst.reply = 1'b1;
			burst.reply_code = item.connect_ok ? REPLY_GRANTED : REPLY_REJECTED;
		end else begin
			unique case (phase_q)
				PH_FORWARD: begin
					single.kind = K_FORWARD;
					single.byte_value = item.data_byte;
					burst.emit = 1'b1;
					burst.item = single;
				end
				PH_HEADER: begin
					bump = 1'b1;
					if (count_q == 16'd1)
						command_d = item.data_byte;
					else if (count_q == 16'd2 || count_q == 16'd3)
						port_d = {port_q[7:0], item.data_byte};
					else if (count_q >= 16'd4 && count_q <= HEADER_LAST)
						addr_d = {addr_q[23:0], item.data_byte};
					if (count_q == HEADER_LAST && command_q != CMD_CONNECT) begin
						burst.emit = 1'b1;
						burst.reply = 1'b1;
						burst.reply_code = REPLY_REJECTED;
						burst.tail_error = 1'b1;
						phase_d = PH_ERROR;
					end else if (count_q == HEADER_LAST && port_q == 16'd0) begin
						burst.emit = 1'b1;
						burst.item = error_item(E_PORT);
						phase_d = PH_ERROR;
					end else begin
						if (count_q == HEADER_LAST)
							phase_d = PH_USERID;
						if (over) begin
							burst.emit = 1'b1;
							burst.item = error_item(E_LENGTH);
							phase_d = PH_ERROR;
						end
					end
				end
				PH_USERID: begin
					bump = 1'b1;
					if (item.data_byte == 8'h00 && |addr_q[31:8]) begin
						single.kind = K_CONNECT;
						single.dest_port = port_q;
						single.dest_ipv4 = addr_q;
						burst.emit = 1'b1;
						burst.item = single;
						phase_d = PH_FORWARD;
					end else begin
						if (item.data_byte == 8'h00)
							phase_d = PH_HOST;
						if (over) begin
							burst.emit = 1'b1;
							burst.item = error_item(E_LENGTH);
							phase_d = PH_ERROR;
						end
					end
				end
				PH_HOST: begin
					bump = 1'b1;
					if (item.data_byte == 8'h00) begin
						single.kind = K_CONNECT;
						single.dest_port = port_q;
						single.uses_hostname = 1'b1;
						burst.item = single;
						phase_d = PH_FORWARD;
					end else if (over) begin
						burst.item = error_item(E_LENGTH);
						phase_d = PH_ERROR;
					end else begin
						single.kind = K_HOSTBYTE;
						single.byte_value = item.data_byte;
						burst.item = single;
					end
					burst.emit = 1'b1;
				end
				default: begin
					burst = '0;
				end
			endcase
		end
		count_d = (bump && count_q != 16'hFFFF) ? count_q + 16'd1 : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			count_q <= '0;
			command_q <= '0;
			port_q <= '0;
			addr_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			count_q <= count_d;
			command_q <= command_d;
			port_q <= port_d;
			addr_q <= addr_d;
		end
	end

endmodule

// ----- src/s4p_emit.sv -----
// output register and reply burst sequencer
`timescale 1ns / 1ps
module s4p_emit import s4p_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  burst_t    burst,
	output logic      free,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic       valid_q;
	out_item_t  out_q;
	logic       rep_q;
	logic [2:0] idx_q;
	logic [7:0] code_q;
	logic       tail_q;
	logic       take;

	assign take = valid_q && !out_stall;
	assign free = !valid_q || (take && out_q.last);
	assign out_valid = valid_q;
	assign out_item = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rep_q <= 1'b0;
		end else if (free) begin
			valid_q <= load && burst.emit;
			rep_q <= load && burst.emit && burst.reply;
		end else if (take && rep_q && idx_q == REPLY_LAST) begin
			rep_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (free) begin
			if (load && burst.emit) begin
				idx_q <= '0;
				code_q <= burst.reply_code;
				tail_q <= burst.tail_error;
				out_q <= burst.reply ? reply_item(3'd0, burst.reply_code, burst.tail_error)
					: burst.item;
			end
		end else if (take && rep_q) begin
			if (idx_q != REPLY_LAST) begin
				idx_q <= idx_q + 3'd1;
				out_q <= reply_item(idx_q + 3'd1, code_q, tail_q);
			end else begin
				out_q <= error_item(E_COMMAND);
			end
		end
	end

endmodule

// ----- src/socks4_request_parser.sv -----
// top level of the socks4 / socks4a connect request parser
// an accepted item is registered in item_s1, parsed, and its first result is registered in out_q
// throughput: one item per cycle for items with at most one result, while out_stall is low
// a connect outcome or rejected command holds input until its 8 or 9 result items are taken
// reset clears phase, the byte counter and header fields; limit_q resets to 512
`timescale 1ns / 1ps
module socks4_request_parser import s4p_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_item,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_item,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic [15:0] limit_q;
	logic        valid_s1;
	in_item_t    item_s1;
	logic        free;
	logic        consume;
	burst_t      burst;

	assign cfg_ready = 1'b1;
	assign consume = valid_s1 && free;
	assign in_stall = valid_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				limit_q <= cfg_data;
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (consume)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_item;
	end

	s4p_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (consume),
		.item   (item_s1),
		.limit  (limit_q),
		.burst  (burst)
	);

	s4p_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (consume),
		.burst     (burst),
		.free      (free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

// ----- src/s4p_checker.sv -----
// port level checks for the socks4 request parser, bound to the top level
`timescale 1ns / 1ps
module s4p_assert_checker import s4p_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item,
	input logic      cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output item changed");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind == K_ERROR |-> out_item.last)
		else $error("error item not marked last");

	a_error_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && out_item.kind == K_ERROR |=> !out_valid)
		else $error("result after error item");

	a_code_only_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.kind != K_ERROR |-> out_item.error_code == E_NONE)
		else $error("error code on non-error item");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n) cfg_ready)
		else $error("config port not ready");

endmodule

bind socks4_request_parser s4p_assert_checker u_s4p_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item),
	.cfg_ready (cfg_ready)
);
